@@ src/hple_pkg.sv @@
// ----------------------------------------------------------------------------
// HPACK literal header encoder package
// Shared widths, item codes, encoding constants and the emit record.
// ----------------------------------------------------------------------------
package hple_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int OFFSET_W    = 32;
    localparam int BYTE_W      = 8;

    // item codes carried in the op field
    localparam logic [1:0] OP_NAME_LEN  = 2'd0;
    localparam logic [1:0] OP_NAME_BYTE = 2'd1;
    localparam logic [1:0] OP_VALUE_LEN = 2'd2;
    localparam logic [1:0] OP_VALUE_BYTE = 2'd3;

    localparam logic [BYTE_W-1:0] LIT_NEVER_IDX = 8'h10;
    localparam logic [BYTE_W-1:0] INT_PREFIX_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] INT_CONT_BIT  = 8'h80;
    localparam int                INT_GROUP_W   = 7;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [OFFSET_W-1:0] BUF_SIZE_RESET = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_emit;

endpackage

@@ src/hple_seq.sv @@
// ----------------------------------------------------------------------------
// HPACK literal header encoder sequencer
// Walks one item through prefix, integer and string steps, one byte a cycle
// unless stalled; two compares, a subtract, a shift for the length integer.
// ----------------------------------------------------------------------------
module hple_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [1:0]                   i_op,
    input  logic [31:0]                  i_length,
    input  logic [hple_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_adv,
    output logic                         o_idle,
    output logic                         o_emit_valid,
    output hple_pkg::t_emit              o_emit
);
    import hple_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_PREFIX    = 3'd1;
    localparam logic [2:0] ST_INT_FIRST = 3'd2;
    localparam logic [2:0] ST_INT_REST  = 3'd3;
    localparam logic [2:0] ST_STR       = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [LENGTH_BITS-1:0] r_val,   n_val;
    logic [BYTE_W-1:0]      r_db,    n_db;

    logic [LENGTH_BITS-1:0] w_prefix_max;
    logic [LENGTH_BITS-1:0] w_cont_bit;
    logic                   w_fits_prefix;
    logic                   w_more_groups;

    assign w_prefix_max  = LENGTH_BITS'(INT_PREFIX_MAX);
    assign w_cont_bit    = LENGTH_BITS'(INT_CONT_BIT);
    assign w_fits_prefix = r_val < w_prefix_max;
    assign w_more_groups = r_val >= w_cont_bit;

    always_comb begin
        n_state      = r_state;
        n_val        = r_val;
        n_db         = r_db;
        o_emit_valid = 1'b0;
        o_emit.data  = r_db;
        o_emit.last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_load) begin
                    n_val = LENGTH_BITS'(i_length);
                    n_db  = i_data_byte;
                    case (i_op)
                        OP_NAME_LEN:  n_state = ST_PREFIX;
                        OP_VALUE_LEN: n_state = ST_INT_FIRST;
                        OP_NAME_BYTE: begin
                            // lowercase ASCII letters in header names
                            if (i_data_byte inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})
                                n_db = i_data_byte - ASCII_UPPER_A + ASCII_LOWER_A;
                            n_state = ST_STR;
                        end
                        default:      n_state = ST_STR;
                    endcase
                end
            end
            ST_PREFIX: begin
                o_emit_valid = 1'b1;
                o_emit.data  = LIT_NEVER_IDX;
                if (i_adv)
                    n_state = ST_INT_FIRST;
            end
            ST_INT_FIRST: begin
                o_emit_valid = 1'b1;
                if (w_fits_prefix) begin
                    o_emit.data = r_val[BYTE_W-1:0];
                    o_emit.last = 1'b1;
                    if (i_adv)
                        n_state = ST_IDLE;
                end else begin
                    o_emit.data = INT_PREFIX_MAX;
                    if (i_adv) begin
                        n_val   = r_val - w_prefix_max;
                        n_state = ST_INT_REST;
                    end
                end
            end
            ST_INT_REST: begin
                o_emit_valid = 1'b1;
                if (w_more_groups) begin
                    o_emit.data = INT_CONT_BIT | {1'b0, r_val[INT_GROUP_W-1:0]};
                    if (i_adv)
                        n_val = r_val >> INT_GROUP_W;
                end else begin
                    o_emit.data = r_val[BYTE_W-1:0];
                    o_emit.last = 1'b1;
                    if (i_adv)
                        n_state = ST_IDLE;
                end
            end
            ST_STR: begin
                o_emit_valid = 1'b1;
                o_emit.data  = r_db;
                o_emit.last  = 1'b1;
                if (i_adv)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_db  <= n_db;
    end

endmodule

@@ src/hpack_literal_header_encoder_top.sv @@
// ----------------------------------------------------------------------------
// HPACK literal header encoder, top level
// The first byte passes the sequencer state, then the output register.
// Throughput: one output byte per cycle while the sequencer emits and the
// output is not back-pressured; a new item is accepted only in idle.
// Reset (synchronous, active low): offset cleared, buffer_size all ones.
// ----------------------------------------------------------------------------
module hpack_literal_header_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // length[31:0], data_byte[39:32]
    input  logic [2:0]  s_axis_tuser,   // op[1:0], block_start[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_byte[7:0], byte_offset[39:8]
    output logic        m_axis_tuser,   // stored
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import hple_pkg::*;

    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_data;
    logic [OFFSET_W-1:0] r_out_off;
    logic                r_out_stored;
    logic                r_out_last;
    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] r_buf_size;

    logic  w_accept;
    logic  w_idle;
    logic  w_adv;
    logic  w_emit_valid;
    t_emit w_emit;
    logic  w_take;

    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = w_idle;
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_take        = w_emit_valid & w_adv;
    assign o_cfg_ready   = 1'b1;

    hple_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_op         (s_axis_tuser[1:0]),
        .i_length     (s_axis_tdata[31:0]),
        .i_data_byte  (s_axis_tdata[39:32]),
        .i_adv        (w_adv),
        .o_idle       (w_idle),
        .o_emit_valid (w_emit_valid),
        .o_emit       (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_offset    <= '0;
            r_buf_size  <= BUF_SIZE_RESET;
        end else begin
            if (i_cfg_valid)
                r_buf_size <= i_cfg_data;
            if (w_accept && s_axis_tuser[2])
                r_offset <= '0;
            else if (w_take && r_offset != OFFSET_MAX)
                r_offset <= r_offset + OFFSET_W'(1);
            // hold the byte until taken, refill when the sequencer advances
            if (w_take)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data   <= w_emit.data;
            r_out_off    <= r_offset;
            r_out_stored <= r_offset < r_buf_size;
            r_out_last   <= w_emit.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_off, r_out_data};
    assign m_axis_tuser  = r_out_stored;
    assign m_axis_tlast  = r_out_last;

    a_no_accept_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_emit_valid)
        else $error("item accepted while sequencer still emitting");

    a_emit_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_valid && !w_adv) |=> (w_emit_valid && $stable(w_emit)))
        else $error("pending byte changed under back-pressure");

    a_offset_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_offset == OFFSET_MAX && !(w_accept && s_axis_tuser[2]))
            |=> (r_offset == OFFSET_MAX))
        else $error("offset wrapped past its maximum");

endmodule
